FILE: rtl/core/tnss_pkg.sv
// Shared types and constants of the timed note step sequencer.
package tnss_pkg;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_START      = 3'd1,
        CMD_STOP       = 3'd2,
        CMD_HOLD       = 3'd3,
        CMD_RELEASE    = 3'd4,
        CMD_WRITE_STEP = 3'd5,
        CMD_WRITE_GAIN = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_GAIN,
        ST_END
    } state_t;

    localparam logic [2:0] REG_SCORE_LENGTH = 3'd0;
    localparam logic [2:0] REG_STEP_COUNT   = 3'd1;
    localparam logic [2:0] REG_LOOP_ENABLE  = 3'd2;
    localparam logic [2:0] REG_MUSIC_LEVEL  = 3'd3;
    localparam logic [2:0] REG_VOICE_LIMIT  = 3'd4;

    localparam logic [15:0] RST_SCORE_LENGTH = 16'd1000;
    localparam logic [8:0]  RST_STEP_COUNT   = 9'd1;
    localparam logic        RST_LOOP_ENABLE  = 1'b0;
    localparam logic [7:0]  RST_MUSIC_LEVEL  = 8'd255;
    localparam logic [4:0]  RST_VOICE_LIMIT  = 5'd12;

    localparam int TIME_W = 26;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [4:0] MAX_OUT = 5'd16;

    // step entry: {time in ms, note}
    localparam int STEP_W = 22;

endpackage

FILE: rtl/core/tnss_ram.sv
// Generic single-port-write, registered-read RAM.
module tnss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/timed_note_step_sequencer.sv
// Top level of the timed note step sequencer: command decode, step walk and note output.
//
// Commands are requests on start/busy: a request is taken at a rising edge with start high
// and busy low. Start, stop, hold, release and the two table writes never raise busy. A
// tick while playing adds elapsed to the score time, then walks the due steps with busy
// high.
// Each step costs a registered read of the step RAM and a compare; an emitted
// step adds a read of the gain RAM and one 16x16 multiply by the squared music level.
// Notes leave on note_index/scaled_gain/last_of_tick, each valid for the single cycle that
// note_strobe is high. A note is held back one step so that last_of_tick can be set on the
// final note of the tick; the last note appears in the first cycle with busy low again.
// The receiver cannot stall; every strobe is a finished note.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next edge and
// are expected only while busy is low.
// Reset: registers return to their defaults, playing and score state clear. The step and
// gain RAMs are not cleared; entries must be written before a score refers to them.
module timed_note_step_sequencer #(
    parameter int STEP_DEPTH = 256,
    parameter int NOTE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] elapsed,
    input  logic [5:0]  live_voices,
    input  logic [7:0]  table_index,
    input  logic [15:0] step_time_ms,
    input  logic [5:0]  step_note,
    input  logic [15:0] note_gain_in,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        note_strobe,
    output logic [5:0]  note_index,
    output logic [15:0] scaled_gain,
    output logic        last_of_tick
);

    import tnss_pkg::*;

    localparam int SAW = $clog2(STEP_DEPTH);
    localparam int NW  = $clog2(STEP_DEPTH + 1);
    localparam int CW  = (NW > 9) ? NW : 9;
    localparam int IW  = (SAW > 8) ? SAW : 8;
    localparam int GAW = $clog2(NOTE_DEPTH);
    localparam int GIW = (GAW > 8) ? GAW : 8;
    localparam int NIW = (GAW > 6) ? GAW : 6;

    // control state
    state_t            state_reg, state_next;
    logic [15:0]       score_length_reg, score_length_next;
    logic [8:0]        step_count_reg, step_count_next;
    logic              loop_enable_reg, loop_enable_next;
    logic [7:0]        music_level_reg, music_level_next;
    logic [4:0]        voice_limit_reg, voice_limit_next;
    logic [TIME_W-1:0] score_time_reg, score_time_next;
    logic [NW-1:0]     next_step_reg, next_step_next;
    logic              playing_reg, playing_next;
    logic              loaded_reg, loaded_next;
    logic [4:0]        n_out_reg, n_out_next;
    logic              pending_valid_reg, pending_valid_next;
    logic              strobe_reg, strobe_next;

    // payload
    logic [5:0]        live_reg, live_next;
    logic [5:0]        note_reg, note_next;
    logic [5:0]        pending_note_reg, pending_note_next;
    logic [15:0]       pending_gain_reg, pending_gain_next;
    logic [5:0]        out_note_reg, out_note_next;
    logic [15:0]       out_gain_reg, out_gain_next;
    logic              out_last_reg, out_last_next;
    logic [15:0]       lvl_sq_reg;

    // memories
    logic              step_we;
    logic              gain_we;
    logic [IW-1:0]     step_idx_ext;
    logic [GIW-1:0]    gain_idx_ext;
    logic [STEP_W-1:0] step_rdata;
    logic [15:0]       gain_rdata;
    logic [NIW-1:0]    gain_raddr_ext;

    logic [15:0]       step_time_rd;
    logic [5:0]        step_note_rd;
    logic [CW-1:0]     count_ext;
    logic [NW-1:0]     active_steps;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] score_len_q;
    logic [6:0]        voices_used;
    logic              headroom;
    logic              note_ok;
    logic [31:0]       gain_prod;
    cmd_t              cmd;

    assign step_idx_ext   = IW'(table_index);
    assign gain_idx_ext   = GIW'(table_index);
    assign step_time_rd   = step_rdata[STEP_W-1:6];
    assign step_note_rd   = step_rdata[5:0];
    assign gain_raddr_ext = NIW'(step_note_rd);

    tnss_ram #(
        .WIDTH (STEP_W),
        .DEPTH (STEP_DEPTH)
    ) u_step_ram (
        .clk   (clk),
        .we    (step_we),
        .waddr (step_idx_ext[SAW-1:0]),
        .wdata ({step_time_ms, step_note}),
        .raddr (next_step_reg[SAW-1:0]),
        .rdata (step_rdata)
    );

    tnss_ram #(
        .WIDTH (16),
        .DEPTH (NOTE_DEPTH)
    ) u_gain_ram (
        .clk   (clk),
        .we    (gain_we),
        .waddr (gain_idx_ext[GAW-1:0]),
        .wdata (note_gain_in),
        .raddr (gain_raddr_ext[GAW-1:0]),
        .rdata (gain_rdata)
    );

    assign cmd          = cmd_t'(command);
    assign count_ext    = CW'(step_count_reg);
    assign active_steps = (count_ext > CW'(STEP_DEPTH)) ? NW'(STEP_DEPTH) : NW'(count_ext);
    assign time_sum     = {1'b0, score_time_reg} + (TIME_W + 1)'(elapsed);
    assign score_len_q  = TIME_W'({score_length_reg, 8'd0});
    assign voices_used  = 7'(live_reg) + 7'(n_out_reg);
    assign headroom     = (voices_used < 7'(voice_limit_reg)) && (n_out_reg < MAX_OUT);
    assign note_ok      = 32'(note_reg) < NOTE_DEPTH;
    assign gain_prod    = 32'(gain_rdata) * 32'(lvl_sq_reg);

    always_comb
    begin
        state_next         = state_reg;
        score_length_next  = score_length_reg;
        step_count_next    = step_count_reg;
        loop_enable_next   = loop_enable_reg;
        music_level_next   = music_level_reg;
        voice_limit_next   = voice_limit_reg;
        score_time_next    = score_time_reg;
        next_step_next     = next_step_reg;
        playing_next       = playing_reg;
        loaded_next        = loaded_reg;
        n_out_next         = n_out_reg;
        pending_valid_next = pending_valid_reg;
        strobe_next        = 1'b0;
        live_next          = live_reg;
        note_next          = note_reg;
        pending_note_next  = pending_note_reg;
        pending_gain_next  = pending_gain_reg;
        out_note_next      = out_note_reg;
        out_gain_next      = out_gain_reg;
        out_last_next      = out_last_reg;
        step_we            = 1'b0;
        gain_we            = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCORE_LENGTH: score_length_next = cfg_data;
                REG_STEP_COUNT:   step_count_next   = cfg_data[8:0];
                REG_LOOP_ENABLE:  loop_enable_next  = cfg_data[0];
                REG_MUSIC_LEVEL:  music_level_next  = cfg_data[7:0];
                REG_VOICE_LIMIT:  voice_limit_next  = cfg_data[4:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_TICK:
                        begin
                            if (playing_reg)
                            begin
                                score_time_next    = time_sum[TIME_W] ? TIME_MAX
                                                                      : time_sum[TIME_W-1:0];
                                live_next          = live_voices;
                                n_out_next         = '0;
                                pending_valid_next = 1'b0;
                                state_next         = ST_FETCH;
                            end
                        end
                        CMD_START:
                        begin
                            if (score_length_reg != '0 && step_count_reg != '0)
                            begin
                                score_time_next = '0;
                                next_step_next  = '0;
                                playing_next    = 1'b1;
                                loaded_next     = 1'b1;
                            end
                        end
                        CMD_STOP:
                        begin
                            playing_next = 1'b0;
                        end
                        CMD_HOLD:
                        begin
                            if (loaded_reg)
                            begin
                                playing_next = 1'b0;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (loaded_reg)
                            begin
                                playing_next = 1'b1;
                            end
                        end
                        CMD_WRITE_STEP:
                        begin
                            step_we = 32'(table_index) < STEP_DEPTH;
                        end
                        CMD_WRITE_GAIN:
                        begin
                            gain_we = 32'(table_index) < NOTE_DEPTH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = (next_step_reg < active_steps) ? ST_CHECK : ST_END;
            end
            ST_CHECK:
            begin
                if (TIME_W'({step_time_rd, 8'd0}) <= score_time_reg)
                begin
                    if (headroom)
                    begin
                        note_next  = step_note_rd;
                        state_next = ST_GAIN;
                    end
                    else
                    begin
                        next_step_next = next_step_reg + 1'b1;
                        state_next     = ST_FETCH;
                    end
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_GAIN:
            begin
                if (pending_valid_reg)
                begin
                    strobe_next   = 1'b1;
                    out_note_next = pending_note_reg;
                    out_gain_next = pending_gain_reg;
                    out_last_next = 1'b0;
                end
                pending_note_next  = note_reg;
                pending_gain_next  = note_ok ? gain_prod[31:16] : 16'd0;
                pending_valid_next = 1'b1;
                n_out_next         = n_out_reg + 1'b1;
                next_step_next     = next_step_reg + 1'b1;
                state_next         = ST_FETCH;
            end
            ST_END:
            begin
                if (pending_valid_reg)
                begin
                    strobe_next   = 1'b1;
                    out_note_next = pending_note_reg;
                    out_gain_next = pending_gain_reg;
                    out_last_next = 1'b1;
                end
                pending_valid_next = 1'b0;
                if (score_time_reg >= score_len_q)
                begin
                    if (loop_enable_reg)
                    begin
                        score_time_next = score_time_reg - score_len_q;
                        next_step_next  = '0;
                    end
                    else
                    begin
                        playing_next = 1'b0;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            score_length_reg  <= RST_SCORE_LENGTH;
            step_count_reg    <= RST_STEP_COUNT;
            loop_enable_reg   <= RST_LOOP_ENABLE;
            music_level_reg   <= RST_MUSIC_LEVEL;
            voice_limit_reg   <= RST_VOICE_LIMIT;
            score_time_reg    <= '0;
            next_step_reg     <= '0;
            playing_reg       <= 1'b0;
            loaded_reg        <= 1'b0;
            n_out_reg         <= '0;
            pending_valid_reg <= 1'b0;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            score_length_reg  <= score_length_next;
            step_count_reg    <= step_count_next;
            loop_enable_reg   <= loop_enable_next;
            music_level_reg   <= music_level_next;
            voice_limit_reg   <= voice_limit_next;
            score_time_reg    <= score_time_next;
            next_step_reg     <= next_step_next;
            playing_reg       <= playing_next;
            loaded_reg        <= loaded_next;
            n_out_reg         <= n_out_next;
            pending_valid_reg <= pending_valid_next;
            strobe_reg        <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        live_reg         <= live_next;
        note_reg         <= note_next;
        pending_note_reg <= pending_note_next;
        pending_gain_reg <= pending_gain_next;
        out_note_reg     <= out_note_next;
        out_gain_reg     <= out_gain_next;
        out_last_reg     <= out_last_next;
        lvl_sq_reg       <= 16'(music_level_reg) * 16'(music_level_reg);
    end

    assign busy         = state_reg != ST_IDLE;
    assign note_strobe  = strobe_reg;
    assign note_index   = out_note_reg;
    assign scaled_gain  = out_gain_reg;
    assign last_of_tick = out_last_reg;

    // notes leave only from the gain or end step of a walk
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        note_strobe |-> ($past(state_reg) == ST_GAIN || $past(state_reg) == ST_END))
        else $error("note strobe outside a step walk");

    // a note flagged last comes from the end of the walk, others from mid-walk
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        note_strobe |-> (last_of_tick == ($past(state_reg) == ST_END)))
        else $error("last_of_tick does not match walk position");

    a_out_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_out_reg <= MAX_OUT)
        else $error("too many notes in one tick");

    a_pending_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_END |=> !pending_valid_reg && state_reg == ST_IDLE)
        else $error("held note not flushed at end of tick");

endmodule
